// File: rtl/core/mqtq_pkg.sv
// Shared types and codes for the multi-queue priority ticket queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package mqtq_pkg;

  localparam int unsigned PRIO_W   = 4;
  localparam int unsigned TICKET_W = 16;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned QSEL_W   = 2;
  localparam int unsigned STATUS_W = 3;

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

  localparam logic [TICKET_W-1:0] TICKET_FIRST = 16'd1;
  localparam logic [TICKET_W-1:0] TICKET_LAST  = 16'hFFFF;

  // One stored queue entry
  typedef struct packed {
    logic [PRIO_W-1:0]   prio;
    logic [TICKET_W-1:0] ticket;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/mqtq_ram.sv
// Entry store: one write port, one registered read port.
// Depends on mqtq_pkg for the entry type.
`default_nettype none

module mqtq_ram
  import mqtq_pkg::*;
#(
  parameter int unsigned AW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem [2**AW];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/core/mqtq_ctrl.sv
// Command sequencer: fill counts, ticket counter, priority scan and shift-down.
// Depends on mqtq_pkg; drives the entry store mqtq_ram.
`default_nettype none

module mqtq_ctrl
  import mqtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NUM_QUEUES  = 3,
  localparam int unsigned KW = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1),
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
  localparam int unsigned AW = QW + KW
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [QSEL_W-1:0]   queue_sel_i,
  input  logic [PRIO_W-1:0]   priority_req_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [TICKET_W-1:0] ticket_o,
  output logic                we_o,
  output logic [AW-1:0]       waddr_o,
  output entry_t              wdata_o,
  output logic [AW-1:0]       raddr_o,
  input  entry_t              rdata_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       cnt_q [NUM_QUEUES];
  logic [CW-1:0]       cnt_d [NUM_QUEUES];
  logic [TICKET_W-1:0] next_q, next_d;
  logic [QW-1:0]       q_q, q_d;
  logic [CW-1:0]       n_q, n_d;
  logic [CW-1:0]       rk_q, rk_d;
  logic [CW-1:0]       sk_q, sk_d;
  logic                pv_q, pv_d;
  logic [KW-1:0]       pk_q, pk_d;
  logic [KW-1:0]       bk_q, bk_d;
  logic [PRIO_W-1:0]   bp_q, bp_d;
  logic [TICKET_W-1:0] bt_q, bt_d;
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [TICKET_W-1:0] ticket_q, ticket_d;

  logic [QW-1:0]       qs;
  logic                sel_ok;
  logic [CW-1:0]       cnt_sel;
  logic [CW-1:0]       sk_inc;
  logic                take;

  assign qs      = QW'(queue_sel_i);
  assign sel_ok  = (32'(queue_sel_i) < NUM_QUEUES);
  assign cnt_sel = sel_ok ? cnt_q[qs] : '0;
  assign sk_inc  = sk_q + CNT_ONE;
  // Shared compare unit: strictly greater keeps the oldest among equals
  assign take    = pv_q && ((pk_q == '0) || (rdata_i.prio > bp_q));

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign ticket_o = ticket_q;

  // Sequence one command
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    next_d   = next_q;
    q_d      = q_q;
    n_d      = n_q;
    rk_d     = rk_q;
    sk_d     = sk_q;
    pv_d     = pv_q;
    pk_d     = pk_q;
    bk_d     = bk_q;
    bp_d     = bp_q;
    bt_d     = bt_q;
    done_d   = 1'b0;
    status_d = status_q;
    ticket_d = ticket_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = '0;
    raddr_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          done_d   = 1'b1;
          status_d = ST_EMPTY;
          ticket_d = '0;
          case (func_i)
            FUNC_INSERT: begin
              if (!sel_ok || (cnt_sel == CNT_FULL)) begin
                status_d = ST_FULL;
              end else begin
                we_o         = 1'b1;
                waddr_o      = {qs, cnt_sel[KW-1:0]};
                wdata_o.prio   = priority_req_i;
                wdata_o.ticket = next_q;
                cnt_d[qs]    = cnt_sel + CNT_ONE;
                next_d       = (next_q == TICKET_LAST) ? TICKET_FIRST
                                                       : next_q + TICKET_FIRST;
                status_d     = ST_INSERTED;
                ticket_d     = next_q;
              end
            end
            FUNC_REMOVE: begin
              if (sel_ok && (cnt_sel != '0)) begin
                done_d  = 1'b0;
                q_d     = qs;
                n_d     = cnt_sel;
                rk_d    = '0;
                pv_d    = 1'b0;
                state_d = S_SCAN;
              end
            end
            FUNC_CLEAR: begin
              for (int i = 0; i < NUM_QUEUES; i++) begin
                cnt_d[i] = '0;
              end
              next_d   = TICKET_FIRST;
              status_d = ST_CLEARED;
            end
            default: begin
              status_d = ST_EMPTY;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue one read per cycle
        if (rk_q < n_q) begin
          raddr_o = {q_q, rk_q[KW-1:0]};
          pv_d    = 1'b1;
          pk_d    = rk_q[KW-1:0];
          rk_d    = rk_q + CNT_ONE;
        end else begin
          pv_d = 1'b0;
        end
        // Track the best entry seen so far
        if (take) begin
          bk_d = pk_q;
          bp_d = rdata_i.prio;
          bt_d = rdata_i.ticket;
        end
        // Last compare done: move on to closing the gap
        if (pv_q && (CW'(pk_q) == n_q - CNT_ONE)) begin
          pv_d    = 1'b0;
          sk_d    = CW'(bk_d);
          state_d = S_SHIFT;
        end
      end

      S_SHIFT: begin
        // Write back the entry read last cycle one slot lower
        if (pv_q) begin
          we_o    = 1'b1;
          waddr_o = {q_q, pk_q};
          wdata_o = rdata_i;
        end
        if (sk_inc < n_q) begin
          raddr_o = {q_q, sk_inc[KW-1:0]};
          pv_d    = 1'b1;
          pk_d    = sk_q[KW-1:0];
          sk_d    = sk_inc;
        end else begin
          pv_d       = 1'b0;
          cnt_d[q_q] = n_q - CNT_ONE;
          done_d     = 1'b1;
          status_d   = ST_REMOVED;
          ticket_d   = bt_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        cnt_q[i] <= '0;
      end
      next_q <= TICKET_FIRST;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      next_q  <= next_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    q_q      <= q_d;
    n_q      <= n_d;
    rk_q     <= rk_d;
    sk_q     <= sk_d;
    pk_q     <= pk_d;
    bk_q     <= bk_d;
    bp_q     <= bp_d;
    bt_q     <= bt_d;
    status_q <= status_d;
    ticket_q <= ticket_d;
  end

endmodule

`default_nettype wire

// File: rtl/core/multi_queue_priority_ticket_queue_top.sv
// Top level of the multi-queue priority ticket queue.
// Depends on mqtq_pkg, mqtq_ram and mqtq_ctrl.
`default_nettype none

// Usage
//   Command channel: drive func_i, queue_sel_i and priority_req_i with start
//   high; the transaction is taken on a rising edge where busy is low.
//   Result channel: done_o is high for exactly one cycle with status_o and
//   ticket_o; the receiver cannot hold it off and must take it then.
// Latency and throughput
//   Insert, clear, and any command that finds nothing to do: result in the
//   cycle after acceptance, busy stays low, so one such command per cycle.
//   Remove from a non-empty queue: busy through a priority scan of every
//   entry, then a shift-down of the entries above the best one; the result
//   comes in the same cycle as busy falls.
//   Both phases use the entry store's one read port, one read per cycle;
//   the scan makes one compare per cycle through the shared comparator.
// Reset
//   Every queue is empty and the ticket counter restarts at 1. Entry storage
//   is not cleared; fill counts decide which entries exist.
//   A clear command has the same effect on the queues as reset.
module multi_queue_priority_ticket_queue_top
  import mqtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NUM_QUEUES  = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [QSEL_W-1:0]   queue_sel_i,
  input  logic [PRIO_W-1:0]   priority_req_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [TICKET_W-1:0] ticket_o
);

  localparam int unsigned KW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned AW = QW + KW;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t        wdata;
  entry_t        rdata;

  // Sequencer
  mqtq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_QUEUES  (NUM_QUEUES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .queue_sel_i    (queue_sel_i),
    .priority_req_i (priority_req_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .ticket_o       (ticket_o),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .raddr_o        (raddr),
    .rdata_i        (rdata)
  );

  // Entry store for all queues
  mqtq_ram #(
    .AW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/mqtq_chk.sv
// Port-level checker for the multi-queue priority ticket queue, with its bind.
// Depends on mqtq_pkg; attaches to multi_queue_priority_ticket_queue_top.
`default_nettype none

module mqtq_chk
  import mqtq_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [FUNC_W-1:0]   func_i,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [TICKET_W-1:0] ticket_o
);

  // Ticket is nonzero exactly when an entry was stamped or returned
  a_ticket_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (((status_o == ST_INSERTED) || (status_o == ST_REMOVED)) ==
                (ticket_o != '0)))
    else $error("ticket does not match status");

  // Clear completes in the next cycle
  a_clear_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == FUNC_CLEAR)) |=>
      (done_o && (status_o == ST_CLEARED) && !busy))
    else $error("clear did not complete");

  // Insert completes in the next cycle, stamped or dropped
  a_insert_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (func_i == FUNC_INSERT)) |=>
      (done_o && ((status_o == ST_INSERTED) || (status_o == ST_FULL))))
    else $error("insert did not complete");

  // A remove that goes busy reports a removed entry as busy drops
  a_remove_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (done_o && (status_o == ST_REMOVED)))
    else $error("remove ended without result");

endmodule

bind multi_queue_priority_ticket_queue_top mqtq_chk u_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .func_i   (func_i),
  .done_o   (done_o),
  .status_o (status_o),
  .ticket_o (ticket_o)
);

`default_nettype wire
